### src/sroc_pkg.sv
package sroc_pkg;

  localparam int CNT_W          = 11;
  localparam int STRIP_W        = 7;
  localparam int HALF_W         = 64;
  localparam int IN_DATA_W      = 136;
  localparam int OUT_DATA_W     = 32;
  localparam int DEFAULT_WINDOW = 100;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clear;
    logic update;
  } sroc_lane_ctl_t;

endpackage

### src/sroc_ram.sv
module sroc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sroc_lane.sv
module sroc_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  sroc_pkg::sroc_lane_ctl_t ctl,
  input  logic                  now_bit,
  input  logic                  old_bit,
  output logic [sroc_pkg::CNT_W-1:0] count
);
  import sroc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.update && (now_bit != old_bit)) begin
      if (now_bit) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/sroc_merge.sv
module sroc_merge #(
  parameter int STRIPS = 128
) (
  input  logic [STRIPS-1:0][sroc_pkg::CNT_W-1:0] counts,
  input  logic [sroc_pkg::STRIP_W-1:0]           strip,
  input  logic [sroc_pkg::CNT_W-1:0]             wl,
  output logic [sroc_pkg::CNT_W-1:0]             hits,
  output logic [sroc_pkg::CNT_W-1:0]             misses
);
  import sroc_pkg::*;

  localparam int IDX_W = $clog2(STRIPS);

  logic in_range;

  assign in_range = (32'(strip) < STRIPS);

  always_comb begin
    hits   = '0;
    misses = '0;
    if (in_range) begin
      hits   = counts[strip[IDX_W-1:0]];
      misses = (wl >= hits) ? (wl - hits) : '0;
    end
  end

endmodule

### src/strip_rolling_occupancy_top.sv
// Sliding-window hit occupancy for one strip readout chip.
// Input stream (s_*): one beat is an event or a query, selected by s_tuser.
// An event carries one hit bit per strip and produces no output beat. A query
// names a strip and produces one output beat on m_* with the strip's hit and
// miss counts over the most recent window_length events.
// Throughput is one beat per cycle for any mix of events and queries while the receiver does not stall; every
// strip has its own counter lane, and the ring of past hit words is one
// memory with a registered read that is issued in the acceptance cycle.
// A query result passes the processing stage and the output register before it
// appears on m_tvalid, and it reflects every event accepted before that query.
// Reset clears all counters and the ring position and sets the window to 100
// events. The ring memory is not swept: a wrap flag makes slots not yet
// written in the current window read as empty, so no clearing pass is needed.
// Writing cfg_wdata with cfg_we clears the window the same way.
// When the receiver stalls, the output register holds its result and one
// more query may advance into the processing stage; further input is refused
// (s_tready low) only while that second query waits. Events never stall.
module strip_rolling_occupancy_top #(
  parameter int WINDOW_MAX = 1024,
  parameter int STRIPS     = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sroc_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: hits_low[63:0], hits_high[127:64], strip[134:128].
  input  logic [sroc_pkg::IN_DATA_W-1:0]     s_tdata,
  // Field: cmd.
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: reported_strip[6:0], hits_in_window[17:7],
  // misses_in_window[28:18].
  output logic [sroc_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import sroc_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int CMP_W   = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int WL_MAX_I = (WINDOW_MAX > CNT_MAX) ? CNT_MAX : WINDOW_MAX;
  localparam int WL_RST_I = (DEFAULT_WINDOW > WL_MAX_I) ? WL_MAX_I : DEFAULT_WINDOW;
  localparam logic [CNT_W-1:0] WL_MAX   = CNT_W'(WL_MAX_I);
  localparam logic [CNT_W-1:0] WL_RESET = CNT_W'(WL_RST_I);

  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > WINDOW_MAX) begin
      r = WL_MAX;
    end
    return r;
  endfunction

  logic [CNT_W-1:0]  wl;
  logic [SLOT_W-1:0] slot;
  logic              wrapped;

  logic              accept_in;
  logic              in_cmd;
  logic [STRIPS-1:0] in_hits;
  logic [STRIP_W-1:0] in_strip;
  logic [SLOT_W:0]   slot_inc;
  logic              slot_wrap;

  // Processing stage.
  logic              b_valid;
  logic              b_cmd;
  logic [STRIPS-1:0] b_hits;
  logic [SLOT_W-1:0] b_slot;
  logic [STRIP_W-1:0] b_strip;
  logic              b_fwd;
  logic              b_zero;
  logic [STRIPS-1:0] b_fwd_word;
  logic              b_stall;
  logic              b_event;

  logic [STRIPS-1:0] ram_rdata;
  logic [STRIPS-1:0] old_word;

  logic [STRIPS-1:0][CNT_W-1:0] counts;
  sroc_lane_ctl_t    lane_ctl;

  logic [CNT_W-1:0]  q_hits;
  logic [CNT_W-1:0]  q_misses;

  logic              out_valid;
  logic [STRIP_W-1:0] out_strip;
  logic [CNT_W-1:0]  out_hits;
  logic [CNT_W-1:0]  out_misses;

  assign in_cmd   = s_tuser;
  assign in_hits  = s_tdata[STRIPS-1:0];
  assign in_strip = s_tdata[2*HALF_W +: STRIP_W];

  assign b_event   = b_valid && (b_cmd == CMD_EVENT);
  assign b_stall   = b_valid && (b_cmd == CMD_QUERY) && out_valid && !m_tready;
  assign s_tready  = !b_stall;
  assign accept_in = s_tvalid && s_tready;

  assign slot_inc  = {1'b0, slot} + (SLOT_W + 1)'(1);
  assign slot_wrap = (CMP_W'(slot_inc) >= CMP_W'(wl));

  always_ff @(posedge clk) begin
    if (rst) begin
      wl      <= WL_RESET;
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (cfg_we) begin
      wl      <= clamp_len(cfg_wdata);
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (accept_in && (in_cmd == CMD_EVENT)) begin
      if (slot_wrap) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot_inc[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_stall) begin
      b_valid <= accept_in;
    end
  end

  // The slot being written by the event now in the processing stage is not yet
  // visible to the memory read issued for the beat being accepted, so a repeat of that slot
  // (window of one) takes the word from the stage instead.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      b_cmd      <= in_cmd;
      b_hits     <= in_hits;
      b_slot     <= slot;
      b_strip    <= in_strip;
      b_zero     <= !wrapped;
      b_fwd      <= b_event && (b_slot == slot);
      b_fwd_word <= b_hits;
    end
  end

  sroc_ram #(
    .WIDTH (STRIPS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (b_event),
    .waddr (b_slot),
    .wdata (b_hits),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (b_fwd) begin
      old_word = b_fwd_word;
    end else if (b_zero) begin
      old_word = '0;
    end else begin
      old_word = ram_rdata;
    end
  end

  assign lane_ctl.clear  = cfg_we;
  assign lane_ctl.update = b_event;

  for (genvar i = 0; i < STRIPS; i++) begin : g_lane
    sroc_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .now_bit (b_hits[i]),
      .old_bit (old_word[i]),
      .count   (counts[i])
    );
  end

  sroc_merge #(
    .STRIPS (STRIPS)
  ) u_merge (
    .counts (counts),
    .strip  (b_strip),
    .wl     (wl),
    .hits   (q_hits),
    .misses (q_misses)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_valid && (b_cmd == CMD_QUERY) && !b_stall) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && (b_cmd == CMD_QUERY) && !b_stall) begin
      out_strip  <= b_strip;
      out_hits   <= q_hits;
      out_misses <= q_misses;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - STRIP_W - 2 * CNT_W)'(0), out_misses, out_hits, out_strip};

  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(slot) < CMP_W'(wl))
    else $error("ring slot outside the window");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (slot == '0) && !wrapped)
    else $error("window write did not restart the ring");

  a_fwd_wrapped: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_fwd |-> !b_zero)
    else $error("forwarded word on a slot not yet written");

  a_query_out: assert property (@(posedge clk) disable iff (rst)
    b_valid && (b_cmd == CMD_QUERY) && !b_stall |=> out_valid)
    else $error("query result lost");

endmodule
